@@ rtl/core/kpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kpe_pkg: shared definitions for the Kronecker power element block
// Field widths, register indexes, fixed-point constants, reciprocal table
// and the command and status structs between controller and datapath.
// ---------------------------------------------------------------------------
package kpe_pkg;

	localparam int MAX_BASE_DEF  = 8;
	localparam int MAX_POWER_DEF = 8;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 17;
	localparam int IDX_W     = 24;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 4;

	localparam logic [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_POWER     = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] BASE_SIZE_RST = CFG_W'(2);
	localparam logic [CFG_W-1:0] POWER_RST     = CFG_W'(1);

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// ceil(2^RECIP_SHIFT / m) gives an exact quotient for any IDX_W-bit dividend
	localparam int RECIP_SHIFT = IDX_W + CFG_W;
	localparam int RECIP_W     = RECIP_SHIFT;

	function automatic logic [RECIP_W-1:0] recip_of(input logic [CFG_W-1:0] m);
		logic [RECIP_W-1:0] r;
		unique case (m)
			4'd3:    r = 28'd89478486;
			4'd4:    r = 28'd67108864;
			4'd5:    r = 28'd53687092;
			4'd6:    r = 28'd44739243;
			4'd7:    r = 28'd38347923;
			4'd8:    r = 28'd33554432;
			4'd9:    r = 28'd29826162;
			4'd10:   r = 28'd26843546;
			4'd11:   r = 28'd24403224;
			4'd12:   r = 28'd22369622;
			4'd13:   r = 28'd20648882;
			4'd14:   r = 28'd19173962;
			4'd15:   r = 28'd17895698;
			default: r = 28'd134217728;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic start;
		logic div;
		logic digit;
		logic mul;
		logic load_out;
		logic write_entry;
	} cmd_t;

	typedef struct packed {
		logic last_digit;
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

@@ rtl/core/kpe_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kpe_if: channel interfaces of the Kronecker power element block
// Input item channel, result channel and configuration write channel.
// ---------------------------------------------------------------------------
interface kpe_item_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [kpe_pkg::IDX_W-1:0] row_index;
	logic [kpe_pkg::IDX_W-1:0] col_index;
	logic [kpe_pkg::VAL_W-1:0] entry_value;

	modport source (output valid, func, row_index, col_index, entry_value, input ready);
	modport sink   (input valid, func, row_index, col_index, entry_value, output ready);
endinterface

interface kpe_result_if;
	logic                      valid;
	logic                      ready;
	logic [kpe_pkg::VAL_W-1:0] element_value;
	logic                      out_of_range;

	modport source (output valid, element_value, out_of_range, input ready);
	modport sink   (input valid, element_value, out_of_range, output ready);
endinterface

interface kpe_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [kpe_pkg::CFG_IDX_W-1:0] index;
	logic [kpe_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/kpe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kpe_ctrl: sequencer of the Kronecker power element block
// Accepts items; for a query, steps the datapath through a divide and a digit
// state per index digit, then hands the result to the output register.
// ---------------------------------------------------------------------------
module kpe_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	input  wire              item_func,
	output logic             item_ready,
	input  kpe_pkg::status_t status,
	output kpe_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_DIGIT = 5'b00100,
		ST_FINAL = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_func == kpe_pkg::FUNC_QUERY) begin
						cmd.start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						cmd.write_entry = 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				cmd.mul = 1'b1;
				state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				cmd.digit = 1'b1;
				state_d   = status.last_digit ? ST_FINAL : ST_DIV;
			end
			ST_FINAL: begin
				cmd.mul = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/kpe_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kpe_datapath: datapath of the Kronecker power element block
// Configuration registers, base table memory, reciprocal digit divider,
// Q1.16 product accumulator and the output register.
// ---------------------------------------------------------------------------
module kpe_datapath #(
	parameter int MAX_BASE  = kpe_pkg::MAX_BASE_DEF,
	parameter int MAX_POWER = kpe_pkg::MAX_POWER_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  kpe_pkg::cmd_t                    cmd,
	output kpe_pkg::status_t                 status,
	input  wire  [kpe_pkg::IDX_W-1:0]        row_index,
	input  wire  [kpe_pkg::IDX_W-1:0]        col_index,
	input  wire  [kpe_pkg::VAL_W-1:0]        entry_value,
	input  wire                              cfg_we,
	input  wire  [kpe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [kpe_pkg::CFG_W-1:0]        cfg_data,
	input  wire                              out_ready,
	output logic                             out_valid,
	output logic [kpe_pkg::VAL_W-1:0]        element_value,
	output logic                             out_of_range
);

	localparam int IDX_W   = kpe_pkg::IDX_W;
	localparam int VAL_W   = kpe_pkg::VAL_W;
	localparam int CFG_W   = kpe_pkg::CFG_W;
	localparam int RCP_W   = kpe_pkg::RECIP_W;
	localparam int PROD_W  = IDX_W + RCP_W;
	localparam int DEPTH   = MAX_BASE * MAX_BASE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int DIG_W   = $clog2(MAX_BASE);
	localparam int CNT_W   = $clog2(MAX_POWER + 1);
	localparam int ACC_P_W = 2 * VAL_W;

	logic [CFG_W-1:0] base_size_q;
	logic [CFG_W-1:0] power_q;
	logic [CFG_W-1:0] m_eff;
	logic [CFG_W-1:0] k_eff;

	logic [IDX_W-1:0] row_x_q;
	logic [IDX_W-1:0] col_x_q;
	logic [IDX_W-1:0] row_quo_q;
	logic [IDX_W-1:0] col_quo_q;
	logic [VAL_W-1:0] acc_q;
	logic [VAL_W-1:0] rdata_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_oor_q;

	logic [VAL_W-1:0] table_mem [DEPTH];

	logic [RCP_W-1:0]   recip;
	logic [PROD_W-1:0]  row_prod;
	logic [PROD_W-1:0]  col_prod;
	logic [IDX_W-1:0]   row_rem;
	logic [IDX_W-1:0]   col_rem;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic               wr_en;
	logic [VAL_W-1:0]   wr_value;
	logic [ACC_P_W-1:0] acc_prod;

	always_comb begin
		if (base_size_q < CFG_W'(2)) begin
			m_eff = CFG_W'(2);
		end else if (int'(base_size_q) > MAX_BASE) begin
			m_eff = CFG_W'(MAX_BASE);
		end else begin
			m_eff = base_size_q;
		end
		if (power_q < CFG_W'(1)) begin
			k_eff = CFG_W'(1);
		end else if (int'(power_q) > MAX_POWER) begin
			k_eff = CFG_W'(MAX_POWER);
		end else begin
			k_eff = power_q;
		end
	end

	assign recip    = kpe_pkg::recip_of(m_eff);
	assign row_prod = PROD_W'(row_x_q) * PROD_W'(recip);
	assign col_prod = PROD_W'(col_x_q) * PROD_W'(recip);
	assign row_rem  = row_x_q - row_quo_q * IDX_W'(m_eff);
	assign col_rem  = col_x_q - col_quo_q * IDX_W'(m_eff);
	assign rd_addr  = ADDR_W'(DIG_W'(row_rem)) * ADDR_W'(MAX_BASE) + ADDR_W'(DIG_W'(col_rem));
	assign wr_addr  = ADDR_W'(DIG_W'(row_index)) * ADDR_W'(MAX_BASE)
		+ ADDR_W'(DIG_W'(col_index));
	assign wr_en    = cmd.write_entry && (row_index < IDX_W'(MAX_BASE))
		&& (col_index < IDX_W'(MAX_BASE));
	assign wr_value = (entry_value > kpe_pkg::ONE_Q) ? kpe_pkg::ONE_Q : entry_value;
	assign acc_prod = ACC_P_W'(acc_q) * ACC_P_W'(rdata_q);

	assign status.last_digit = (CFG_W'(cnt_q) + CFG_W'(1)) == k_eff;
	assign status.out_busy   = out_valid_q && !out_ready;

	assign out_valid     = out_valid_q;
	assign element_value = out_value_q;
	assign out_of_range  = out_oor_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_value;
		end
		if (cmd.digit) begin
			rdata_q <= table_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_size_q <= kpe_pkg::BASE_SIZE_RST;
			power_q     <= kpe_pkg::POWER_RST;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					kpe_pkg::REG_BASE_SIZE: base_size_q <= cfg_data;
					kpe_pkg::REG_POWER:     power_q     <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.start) begin
				cnt_q  <= '0;
				pend_q <= 1'b0;
			end else if (cmd.digit) begin
				cnt_q  <= cnt_q + CNT_W'(1);
				pend_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_x_q <= row_index;
			col_x_q <= col_index;
			acc_q   <= kpe_pkg::ONE_Q;
		end
		if (cmd.div) begin
			row_quo_q <= row_prod[PROD_W-1 -: IDX_W];
			col_quo_q <= col_prod[PROD_W-1 -: IDX_W];
		end
		if (cmd.digit) begin
			row_x_q <= row_quo_q;
			col_x_q <= col_quo_q;
		end
		if (cmd.mul && pend_q) begin
			acc_q <= acc_prod[kpe_pkg::FRAC_BITS +: VAL_W];
		end
		if (cmd.load_out) begin
			out_oor_q   <= (row_x_q != '0) || (col_x_q != '0);
			out_value_q <= ((row_x_q != '0) || (col_x_q != '0)) ? '0 : acc_q;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/kronecker_power_element.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kronecker_power_element: element of the K-th Kronecker power of a matrix
// Channels: item (load or query), result (one per query), cfg (register write).
// A load item with func 0 writes one base table entry in its accept cycle,
// saturated to 1.0; loads outside the table are dropped.
// A query item with func 1 splits both indices into K base-m digits and
// multiplies the selected Q1.16 entries, truncating each product.
// For each digit a reciprocal multiply gives the quotient, then the remainder
// selects the base table read. The accumulator multiply overlaps the next
// quotient. A new item is taken only once a query's result is registered;
// K is the clamped power.
// Indices at or above m^K return zero with out_of_range set.
// The result register holds its value while result.ready is low; a finished
// query waits until it is free, then moves in and the next item is taken.
// Reset returns base_size to 2, power to 1 and empties the result register;
// the base table holds no defined value until written. cfg is always ready;
// the user must write it only while no query is in flight; no check is made.
// ---------------------------------------------------------------------------
module kronecker_power_element #(
	parameter int MAX_BASE  = kpe_pkg::MAX_BASE_DEF,
	parameter int MAX_POWER = kpe_pkg::MAX_POWER_DEF
) (
	input wire             clk,
	input wire             arst_n,
	kpe_item_if.sink       item,
	kpe_result_if.source   result,
	kpe_cfg_if.sink        cfg
);

	kpe_pkg::cmd_t    cmd;
	kpe_pkg::status_t status;

	assign cfg.ready = 1'b1;

	kpe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_func  (item.func),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	kpe_datapath #(
		.MAX_BASE  (MAX_BASE),
		.MAX_POWER (MAX_POWER)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.row_index     (item.row_index),
		.col_index     (item.col_index),
		.entry_value   (item.entry_value),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.element_value (result.element_value),
		.out_of_range  (result.out_of_range)
	);

endmodule
`default_nettype wire

@@ bench/tb_kronecker_power_element.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_kronecker_power_element: self-checking bench for the power element unit
// Loads base tables and queries power matrix elements under a range of base
// size and power settings, including clamped register values. A behavioral
// model of the table and the digit product predicts every result, which is
// compared field by field in arrival order. Both channels idle at random and
// the result side holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb_kronecker_power_element;

	localparam int IDX_W     = kpe_pkg::IDX_W;
	localparam int VAL_W     = kpe_pkg::VAL_W;
	localparam int CFG_W     = kpe_pkg::CFG_W;
	localparam int CFG_IDX_W = kpe_pkg::CFG_IDX_W;
	localparam int FRAC_BITS = kpe_pkg::FRAC_BITS;

	localparam int TBL_DIM      = 8;
	localparam int SLOT_W       = $clog2(TBL_DIM * TBL_DIM);
	localparam int POWER_CAP    = 8;
	localparam int RUN_LIMIT    = 600000;
	localparam int DRAIN_CYCLES = 2 * POWER_CAP + 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int INDEX_TOP    = (1 << IDX_W) - 1;
	localparam int NUM_PHASES   = 11;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
	} matrix_op_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             oor;
	} element_t;

	logic clk;
	logic arst_n;

	kpe_item_if   item ();
	kpe_result_if result ();
	kpe_cfg_if    cfg ();

	kronecker_power_element dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	matrix_op_t       op_q[$];
	element_t         element_q[$];
	logic [VAL_W-1:0] base_model [TBL_DIM*TBL_DIM];
	bit               written [TBL_DIM*TBL_DIM];
	logic [CFG_W-1:0] size_reg;
	logic [CFG_W-1:0] power_reg;

	logic [1:0] mode;
	int  errors;
	int  ops_queued;
	int  ops_taken;
	int  results_seen;
	int  cycle_count;
	int  stall_left;
	bit  hold_done;
	bit  item_fire;

	int src_idle  [3] = '{15, 63, 0};
	int sink_idle [3] = '{63, 15, 0};
	int size_set  [NUM_PHASES] = '{8, 3, 2, 8, 0, 15, 5, 7, 1, 6, 4};
	int power_set [NUM_PHASES] = '{8, 5, 8, 1, 0, 12, 3, 2, 15, 4, 6};

	function automatic logic [SLOT_W-1:0] slot_of(int r, int c);
		return SLOT_W'(r * TBL_DIM + c);
	endfunction

	function automatic int radix_of(logic [CFG_W-1:0] r);
		return (r < 2) ? 2 : (r > TBL_DIM) ? TBL_DIM : int'(r);
	endfunction

	function automatic int digits_of(logic [CFG_W-1:0] r);
		return (r < 1) ? 1 : (r > POWER_CAP) ? POWER_CAP : int'(r);
	endfunction

	function automatic longint span_of(int m, int k);
		longint s;
		s = 1;
		for (int d = 0; d < k; d++)
			s = s * m;
		return s;
	endfunction

	function automatic element_t predict_element(matrix_op_t op);
		element_t         e;
		int               m;
		int               k;
		longint           span;
		int               r;
		int               c;
		logic [33:0]      acc;
		m    = radix_of(size_reg);
		k    = digits_of(power_reg);
		span = span_of(m, k);
		r    = int'(op.row);
		c    = int'(op.col);
		if (r >= span || c >= span) begin
			e.value = '0;
			e.oor   = 1'b1;
			return e;
		end
		acc = 34'(kpe_pkg::ONE_Q);
		for (int d = 0; d < k; d++) begin
			acc = (acc * 34'(base_model[slot_of(r % m, c % m)])) >> FRAC_BITS;
			r   = r / m;
			c   = c / m;
		end
		e.value = acc[VAL_W-1:0];
		e.oor   = 1'b0;
		return e;
	endfunction

	function automatic logic [VAL_W-1:0] draw_entry();
		case ($urandom_range(0, 9))
			0:       return kpe_pkg::ONE_Q;
			1, 2:    return VAL_W'($urandom);
			3, 4:    return VAL_W'($urandom_range(0, 65536));
			default: return VAL_W'($urandom_range(60000, 65536));
		endcase
	endfunction

	function automatic void push_op(logic func, int row, int col, logic [VAL_W-1:0] value);
		matrix_op_t op;
		op.func  = func;
		op.row   = IDX_W'(row);
		op.col   = IDX_W'(col);
		op.value = value;
		if (func == kpe_pkg::FUNC_LOAD && op.row < TBL_DIM && op.col < TBL_DIM)
			written[slot_of(int'(op.row), int'(op.col))] = 1'b1;
		op_q.push_back(op);
		ops_queued++;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		if (idx == kpe_pkg::REG_BASE_SIZE)
			size_reg = value;
		else
			power_reg = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (ops_taken != ops_queued || element_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic fill_and_sweep(input int m, input int k, input int n_random);
		longint span;
		int     top;
		int     sel;
		int     row;
		int     col;
		span = span_of(m, k);
		top  = int'(span - 1);
		for (int r = 0; r < m; r++)
			for (int c = 0; c < m; c++)
				if (!written[slot_of(r, c)])
					push_op(kpe_pkg::FUNC_LOAD, r, c, draw_entry());
		push_op(kpe_pkg::FUNC_QUERY, top, top, VAL_W'($urandom));
		push_op(kpe_pkg::FUNC_QUERY, 0, 0, VAL_W'($urandom));
		push_op(kpe_pkg::FUNC_QUERY, top, 0, VAL_W'($urandom));
		if (span <= INDEX_TOP) begin
			push_op(kpe_pkg::FUNC_QUERY, int'(span), 0, VAL_W'($urandom));
			push_op(kpe_pkg::FUNC_QUERY, 0, int'(span), VAL_W'($urandom));
			push_op(kpe_pkg::FUNC_QUERY, INDEX_TOP, INDEX_TOP, VAL_W'($urandom));
		end
		for (int i = 0; i < n_random; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				push_op(kpe_pkg::FUNC_LOAD, $urandom_range(0, TBL_DIM - 1),
					$urandom_range(0, TBL_DIM - 1), draw_entry());
			end else if (sel < 20) begin
				push_op(kpe_pkg::FUNC_LOAD, $urandom, $urandom, VAL_W'($urandom));
			end else if (sel < 85 || span > INDEX_TOP) begin
				if (span > INDEX_TOP && sel >= 85)
					push_op(kpe_pkg::FUNC_QUERY, $urandom, $urandom, VAL_W'($urandom));
				else
					push_op(kpe_pkg::FUNC_QUERY, $urandom_range(0, top),
						$urandom_range(0, top), VAL_W'($urandom));
			end else begin
				row = $urandom_range(int'(span), INDEX_TOP);
				col = $urandom_range(0, 1) ? $urandom : $urandom_range(0, top);
				if ($urandom_range(0, 1))
					push_op(kpe_pkg::FUNC_QUERY, row, col, VAL_W'($urandom));
				else
					push_op(kpe_pkg::FUNC_QUERY, col, row, VAL_W'($urandom));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		element_t  want;
		matrix_op_t op;
		if (!arst_n) begin
			item_fire <= 1'b0;
		end else begin
			item_fire <= item.valid && item.ready;
			if (result.valid && result.ready) begin
				results_seen++;
				if (element_q.size() == 0) begin
					$display("%0t: unexpected result element_value %0d out_of_range %0d",
						$time, result.element_value, result.out_of_range);
					errors++;
				end else begin
					want = element_q.pop_front();
					if (result.element_value !== want.value) begin
						$display("%0t: element_value expected %0d actual %0d",
							$time, want.value, result.element_value);
						errors++;
					end
					if (result.out_of_range !== want.oor) begin
						$display("%0t: out_of_range expected %0d actual %0d",
							$time, want.oor, result.out_of_range);
						errors++;
					end
				end
			end
			if (item.valid && item.ready) begin
				ops_taken++;
				op.func  = item.func;
				op.row   = item.row_index;
				op.col   = item.col_index;
				op.value = item.entry_value;
				if (op.func == kpe_pkg::FUNC_QUERY)
					element_q.push_back(predict_element(op));
				else if (op.row < TBL_DIM && op.col < TBL_DIM)
					base_model[slot_of(int'(op.row), int'(op.col))] =
						(op.value > kpe_pkg::ONE_Q) ? kpe_pkg::ONE_Q : op.value;
			end
		end
	end

	always @(negedge clk) begin : driver
		matrix_op_t nxt;
		if (!arst_n) begin
			item.valid <= 1'b0;
		end else if (!item.valid || item_fire) begin
			if (op_q.size() > 0 && $urandom_range(0, 99) >= src_idle[mode]) begin
				nxt = op_q.pop_front();
				item.valid       <= 1'b1;
				item.func        <= nxt.func;
				item.row_index   <= nxt.row;
				item.col_index   <= nxt.col;
				item.entry_value <= nxt.value;
			end else begin
				item.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (stall_left > 0) begin
			result.ready <= 1'b0;
			stall_left--;
		end else if (!hold_done && results_seen >= 30) begin
			hold_done = 1'b1;
			stall_left = HOLD_CYCLES;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(0, 99) >= sink_idle[mode]);
		end
	end

	initial begin
		arst_n           = 1'b0;
		item.valid       = 1'b0;
		item.func        = kpe_pkg::FUNC_LOAD;
		item.row_index   = '0;
		item.col_index   = '0;
		item.entry_value = '0;
		result.ready     = 1'b0;
		cfg.valid        = 1'b0;
		cfg.index        = kpe_pkg::REG_BASE_SIZE;
		cfg.data         = '0;
		size_reg         = kpe_pkg::BASE_SIZE_RST;
		power_reg        = kpe_pkg::POWER_RST;
		mode             = 2'd0;
		errors           = 0;
		ops_queued       = 0;
		ops_taken        = 0;
		results_seen     = 0;
		cycle_count      = 0;
		stall_left       = 0;
		hold_done        = 1'b0;
		for (int i = 0; i < TBL_DIM * TBL_DIM; i++) begin
			written[i]    = 1'b0;
			base_model[i] = '0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		push_op(kpe_pkg::FUNC_LOAD, 0, 0, kpe_pkg::ONE_Q);
		push_op(kpe_pkg::FUNC_LOAD, 0, 1, 17'h1FFFF);
		push_op(kpe_pkg::FUNC_LOAD, 1, 0, 17'h00000);
		push_op(kpe_pkg::FUNC_LOAD, 1, 1, 17'h08000);
		push_op(kpe_pkg::FUNC_LOAD, TBL_DIM - 1, TBL_DIM - 1, 17'h1FFFF);
		push_op(kpe_pkg::FUNC_LOAD, TBL_DIM, 0, 17'h00000);
		push_op(kpe_pkg::FUNC_LOAD, INDEX_TOP, INDEX_TOP, 17'h1FFFF);
		push_op(kpe_pkg::FUNC_QUERY, 0, 0, 17'h1FFFF);
		push_op(kpe_pkg::FUNC_QUERY, 0, 1, 17'h00000);
		push_op(kpe_pkg::FUNC_QUERY, 1, 0, 17'h00000);
		push_op(kpe_pkg::FUNC_QUERY, 1, 1, 17'h00000);
		push_op(kpe_pkg::FUNC_QUERY, 2, 0, 17'h00000);
		push_op(kpe_pkg::FUNC_QUERY, 0, 2, 17'h00000);
		push_op(kpe_pkg::FUNC_QUERY, INDEX_TOP, INDEX_TOP, 17'h1FFFF);
		push_op(kpe_pkg::FUNC_QUERY, 1, INDEX_TOP, 17'h00000);
		fill_and_sweep(radix_of(size_reg), digits_of(power_reg), 30);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			mode = 2'((p + 1) / 4);
			write_reg(kpe_pkg::REG_BASE_SIZE, CFG_W'(size_set[p]));
			write_reg(kpe_pkg::REG_POWER, CFG_W'(power_set[p]));
			fill_and_sweep(radix_of(size_reg), digits_of(power_reg), 46);
		end

		wait_idle();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/kpe_pkg.sv
rtl/core/kpe_if.sv
rtl/core/kpe_ctrl.sv
rtl/core/kpe_datapath.sv
rtl/core/kronecker_power_element.sv
bench/tb_kronecker_power_element.sv
